// File: hdl/psd_pkg.sv
// Shared types and constants for the plaquette string detector.
package psd_pkg;

    // Input item field layout (s_tdata), lowest bit first
    localparam int COORD_W      = 5;
    localparam int SAMPLE_W     = 16;
    localparam int CELL_X_LSB   = 0;
    localparam int CELL_Y_LSB   = CELL_X_LSB + COORD_W;
    localparam int CELL_Z_LSB   = CELL_Y_LSB + COORD_W;
    localparam int REAL_LSB     = CELL_Z_LSB + COORD_W;
    localparam int IMAG_LSB     = REAL_LSB + SAMPLE_W;
    localparam int S_TDATA_W    = 48;

    // Result item layout (m_tdata), lowest bit first
    localparam int HIT_ANY_BIT  = 0;
    localparam int HIT_XY_BIT   = 1;
    localparam int HIT_YZ_BIT   = 2;
    localparam int HIT_ZX_BIT   = 3;
    localparam int M_TDATA_W    = 8;

    localparam int NUM_CORNERS  = 7;
    localparam int NUM_EDGES    = 9;
    localparam int DRAIN_CYCLES = 2;
    localparam int CNT_W        = 4;
    localparam int ACC_W        = 4;
    localparam int STRING_WINDING = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Lattice corners touched by one query, in read order
    typedef enum logic [2:0] {
        C_O  = 3'd0,
        C_X  = 3'd1,
        C_XY = 3'd2,
        C_Y  = 3'd3,
        C_YZ = 3'd4,
        C_Z  = 3'd5,
        C_XZ = 3'd6
    } corner_t;

    // Distinct directed edges of the three plaquettes
    typedef enum logic [3:0] {
        E_O_X   = 4'd0,
        E_X_XY  = 4'd1,
        E_XY_Y  = 4'd2,
        E_Y_O   = 4'd3,
        E_Y_YZ  = 4'd4,
        E_YZ_Z  = 4'd5,
        E_Z_O   = 4'd6,
        E_Z_XZ  = 4'd7,
        E_XZ_X  = 4'd8
    } edge_t;

    typedef struct packed {
        logic    capture;
        logic    mem_wr;
        logic    rd_en;
        corner_t rd_corner;
        logic    edge_en;
        edge_t   edge_sel;
        logic    load_out;
    } ctrl_cmd_t;

endpackage

// File: hdl/plaquette_string_detector.sv
// Top level of the plaquette string detector.
//
// Input channel s_*: one transfer is one item. s_tuser[0] is the kind: 0 stores a
// complex sample at a lattice cell, 1 queries the cell for strings. Coordinates
// are reduced modulo LATTICE_SIDE; samples keep their low SAMPLE_BITS bits.
// Result channel m_*: exactly one result per item, in order. m_tuser[0] is 1 for
// a query answer and 0 for a write acknowledge (all hit bits zero).
// Timing: s_tready is high only while the sequencer is idle. A write goes
// straight to the finish step, which loads its acknowledge into the result
// register. A query runs its corner reads through the single lattice memory port,
// its edges through one shared edge unit (two multipliers, then a compare), a
// pipeline drain and a finish step that loads the result register.
// An output register holds one finished result, so the next item is accepted
// while it waits; if m_tready stays low the sequencer holds in its finish step
// and takes no further item until the register frees up.
// Reset clears the sequencer and the valid flags; the lattice memory keeps its
// contents and cells must be written before they are queried.
module plaquette_string_detector
    import psd_pkg::*;
#(
    parameter int LATTICE_SIDE = 32,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cell_x, cell_y, cell_z, sample_real, sample_imag, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // string_hit, hit_xy, hit_yz, hit_zx, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // answered_query
    output logic [0:0]           m_tuser
);

    ctrl_cmd_t cmd;

    psd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    psd_dpath #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// File: hdl/psd_ctrl.sv
// Sequencer for the plaquette string detector: reads, edge issue, result handoff.
module psd_ctrl
    import psd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [0:0] s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EDGE  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             accept;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.rd_corner = C_O;
        cmd.edge_sel  = E_O_X;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = accept;
                cmd.mem_wr  = accept && (s_tuser[0] == KIND_WRITE);
                if (accept) begin
                    cnt_next   = '0;
                    state_next = (s_tuser[0] == KIND_QUERY) ? ST_READ : ST_FIN;
                end
            end
            ST_READ: begin
                cmd.rd_en     = 1'b1;
                cmd.rd_corner = corner_t'(cnt_reg[2:0]);
                if (cnt_reg == CNT_W'(NUM_CORNERS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_EDGE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EDGE: begin
                // last corner reaches its corner register during this state; it is used by the late edges only
                cmd.edge_en  = 1'b1;
                cmd.edge_sel = edge_t'(cnt_reg);
                if (cnt_reg == CNT_W'(NUM_EDGES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == CNT_W'(DRAIN_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                cmd.load_out = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while a result still waits");

    // a query starts its corner reads right after the transfer
    a_query_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser[0] == KIND_QUERY) |=> (state_reg == ST_READ && cnt_reg == '0))
        else $error("query did not start reading corners");

    // a result becomes valid only out of the finish step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result valid raised outside the finish step");

endmodule

// File: hdl/psd_dpath.sv
// Datapath: lattice memory, corner registers, shared edge unit, winding sums, result register.
module psd_dpath
    import psd_pkg::*;
#(
    parameter int LATTICE_SIDE = 32,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser
);

    localparam int CW    = $clog2(LATTICE_SIDE);
    localparam int CELLS = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = 2 * SAMPLE_BITS;

    // coordinate reduction modulo the side, as a 32-entry table
    function automatic logic [CW-1:0] wrap_coord(input logic [COORD_W-1:0] c);
        logic [CW-1:0] r;
        r = '0;
        for (int i = 0; i < 2**COORD_W; i++) begin
            if (c == COORD_W'(i)) begin
                r = CW'(i % LATTICE_SIDE);
            end
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] next_coord(input logic [CW-1:0] c);
        return (c == CW'(LATTICE_SIDE - 1)) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                input logic [CW-1:0] cy,
                                                input logic [CW-1:0] cz);
        return AW'((AW'(cx) * AW'(LATTICE_SIDE) + AW'(cy)) * AW'(LATTICE_SIDE)
                   + AW'(cz));
    endfunction

    // item fields
    logic [CW-1:0]        in_x, in_y, in_z;
    logic signed [SAMPLE_W-1:0] in_real, in_imag;
    logic [PW-1:0]        wr_entry;

    assign in_x    = wrap_coord(s_tdata[CELL_X_LSB +: COORD_W]);
    assign in_y    = wrap_coord(s_tdata[CELL_Y_LSB +: COORD_W]);
    assign in_z    = wrap_coord(s_tdata[CELL_Z_LSB +: COORD_W]);
    assign in_real = signed'(s_tdata[REAL_LSB +: SAMPLE_W]);
    assign in_imag = signed'(s_tdata[IMAG_LSB +: SAMPLE_W]);
    // entry = {imag, real}; the size cast sign-extends or truncates
    assign wr_entry = {SB'(in_imag), SB'(in_real)};

    // latched query cell and its wrapped neighbors
    logic [CW-1:0] x_reg, y_reg, z_reg, x1_reg, y1_reg, z1_reg;
    logic          kind_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg    <= in_x;
            y_reg    <= in_y;
            z_reg    <= in_z;
            x1_reg   <= next_coord(in_x);
            y1_reg   <= next_coord(in_y);
            z1_reg   <= next_coord(in_z);
            kind_reg <= s_tuser[0];
        end
    end

    // corner address for the current read
    logic [CW-1:0] rx, ry, rz;
    logic [AW-1:0] mem_addr;

    always_comb begin
        unique case (cmd.rd_corner)
            C_O:     begin rx = x_reg;  ry = y_reg;  rz = z_reg;  end
            C_X:     begin rx = x1_reg; ry = y_reg;  rz = z_reg;  end
            C_XY:    begin rx = x1_reg; ry = y1_reg; rz = z_reg;  end
            C_Y:     begin rx = x_reg;  ry = y1_reg; rz = z_reg;  end
            C_YZ:    begin rx = x_reg;  ry = y1_reg; rz = z1_reg; end
            C_Z:     begin rx = x_reg;  ry = y_reg;  rz = z1_reg; end
            C_XZ:    begin rx = x1_reg; ry = y_reg;  rz = z1_reg; end
            default: begin rx = x_reg;  ry = y_reg;  rz = z_reg;  end
        endcase
    end

    // single port: writes happen only on the transfer cycle, reads only later
    assign mem_addr = cmd.mem_wr ? cell_addr(in_x, in_y, in_z) : cell_addr(rx, ry, rz);

    logic [PW-1:0] mem [CELLS];
    logic [PW-1:0] rd_data_reg;
    corner_t       rd_corner_reg;
    logic          rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[mem_addr] <= wr_entry;
        end
        if (cmd.rd_en) begin
            rd_data_reg   <= mem[mem_addr];
            rd_corner_reg <= cmd.rd_corner;
        end
    end

    logic [PW-1:0] corner_reg [NUM_CORNERS];

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            corner_reg[rd_corner_reg] <= rd_data_reg;
        end
    end

    // edge unit, stage 1: pick ends, cross products
    logic [PW-1:0]         ea, eb;
    logic signed [SB-1:0]  a_re, a_im, b_re, b_im;
    logic signed [PW-1:0]  p_next, q_next;
    logic                  opp_next;

    always_comb begin
        unique case (cmd.edge_sel)
            E_O_X:   begin ea = corner_reg[C_O];  eb = corner_reg[C_X];  end
            E_X_XY:  begin ea = corner_reg[C_X];  eb = corner_reg[C_XY]; end
            E_XY_Y:  begin ea = corner_reg[C_XY]; eb = corner_reg[C_Y];  end
            E_Y_O:   begin ea = corner_reg[C_Y];  eb = corner_reg[C_O];  end
            E_Y_YZ:  begin ea = corner_reg[C_Y];  eb = corner_reg[C_YZ]; end
            E_YZ_Z:  begin ea = corner_reg[C_YZ]; eb = corner_reg[C_Z];  end
            E_Z_O:   begin ea = corner_reg[C_Z];  eb = corner_reg[C_O];  end
            E_Z_XZ:  begin ea = corner_reg[C_Z];  eb = corner_reg[C_XZ]; end
            E_XZ_X:  begin ea = corner_reg[C_XZ]; eb = corner_reg[C_X];  end
            default: begin ea = corner_reg[C_O];  eb = corner_reg[C_X];  end
        endcase
    end

    assign a_re     = signed'(ea[SB-1:0]);
    assign a_im     = signed'(ea[PW-1:SB]);
    assign b_re     = signed'(eb[SB-1:0]);
    assign b_im     = signed'(eb[PW-1:SB]);
    assign p_next   = a_im * b_re;
    assign q_next   = a_re * b_im;
    assign opp_next = (a_im < 0 && b_im > 0) || (a_im > 0 && b_im < 0);

    logic signed [PW-1:0] p_reg, q_reg;
    logic                 opp_reg;
    edge_t                edge_s1_reg, edge_s2_reg;
    logic                 s1_valid_reg, s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.edge_en) begin
            p_reg       <= p_next;
            q_reg       <= q_next;
            opp_reg     <= opp_next;
            edge_s1_reg <= cmd.edge_sel;
        end
    end

    // stage 2: sign of the difference, zero unless the ends' imaginary parts have opposite signs
    logic signed [1:0] sign_next, sign_reg;

    always_comb begin
        priority if (!opp_reg) begin
            sign_next = 2'sd0;
        end else if (p_reg > q_reg) begin
            sign_next = 2'sd1;
        end else if (p_reg < q_reg) begin
            sign_next = -2'sd1;
        end else begin
            sign_next = 2'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            sign_reg    <= sign_next;
            edge_s2_reg <= edge_s1_reg;
        end
    end

    // stage 3: per-plaquette winding sums; shared edges enter one sum reversed
    logic signed [ACC_W-1:0] acc_xy_reg, acc_yz_reg, acc_zx_reg;
    logic signed [ACC_W-1:0] acc_xy_next, acc_yz_next, acc_zx_next;
    logic signed [ACC_W-1:0] step;

    assign step = ACC_W'(sign_reg);

    always_comb begin
        acc_xy_next = acc_xy_reg;
        acc_yz_next = acc_yz_reg;
        acc_zx_next = acc_zx_reg;
        unique case (edge_s2_reg)
            E_O_X:   begin acc_xy_next = acc_xy_reg + step; acc_zx_next = acc_zx_reg - step; end
            E_X_XY:  acc_xy_next = acc_xy_reg + step;
            E_XY_Y:  acc_xy_next = acc_xy_reg + step;
            E_Y_O:   begin acc_xy_next = acc_xy_reg + step; acc_yz_next = acc_yz_reg - step; end
            E_Y_YZ:  acc_yz_next = acc_yz_reg + step;
            E_YZ_Z:  acc_yz_next = acc_yz_reg + step;
            E_Z_O:   begin acc_yz_next = acc_yz_reg + step; acc_zx_next = acc_zx_reg - step; end
            E_Z_XZ:  acc_zx_next = acc_zx_reg + step;
            E_XZ_X:  acc_zx_next = acc_zx_reg + step;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            acc_xy_reg <= '0;
            acc_yz_reg <= '0;
            acc_zx_reg <= '0;
        end else if (s2_valid_reg) begin
            acc_xy_reg <= acc_xy_next;
            acc_yz_reg <= acc_yz_next;
            acc_zx_reg <= acc_zx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
            s1_valid_reg <= cmd.edge_en;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // result register
    logic hit_xy, hit_yz, hit_zx;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_query_reg;

    assign hit_xy = (kind_reg == KIND_QUERY) &&
                    (acc_xy_reg == ACC_W'(STRING_WINDING) ||
                     acc_xy_reg == -ACC_W'(STRING_WINDING));
    assign hit_yz = (kind_reg == KIND_QUERY) &&
                    (acc_yz_reg == ACC_W'(STRING_WINDING) ||
                     acc_yz_reg == -ACC_W'(STRING_WINDING));
    assign hit_zx = (kind_reg == KIND_QUERY) &&
                    (acc_zx_reg == ACC_W'(STRING_WINDING) ||
                     acc_zx_reg == -ACC_W'(STRING_WINDING));

    always_comb begin
        out_data_next              = '0;
        out_data_next[HIT_ANY_BIT] = hit_xy || hit_yz || hit_zx;
        out_data_next[HIT_XY_BIT]  = hit_xy;
        out_data_next[HIT_YZ_BIT]  = hit_yz;
        out_data_next[HIT_ZX_BIT]  = hit_zx;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg  <= out_data_next;
            out_query_reg <= kind_reg;
        end
    end

    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_query_reg;

    // edge pipeline is empty when a result is formed
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!s1_valid_reg && !s2_valid_reg && !rd_valid_reg))
        else $error("result formed with edges still in flight");

    // memory port is never shared by a read and a write
    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mem_wr && cmd.rd_en))
        else $error("read and write on the lattice memory in one cycle");

    // no corner read is still in flight when the edges that use the last corner run
    a_corner_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.edge_en && (cmd.edge_sel == E_Z_XZ || cmd.edge_sel == E_XZ_X))
            |-> !rd_valid_reg)
        else $error("edge issued before its corner arrived");

endmodule
